// ===== design/afc_pkg.sv =====
package afc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int PLANE_W     = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int COORD_W     = 16;

    // result codes
    typedef enum logic [1:0] {
        CLASS_INSIDE  = 2'd0,
        CLASS_CLIPPED = 2'd1,
        CLASS_HIDDEN  = 2'd2
    } t_clip_class;

    // one box, Q10.6 corners
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    // per-plane outcome
    typedef struct packed {
        logic neg_out;
        logic pos_out;
    } t_plane_hit;

endpackage

// ===== design/afc_plane_test.sv =====
module afc_plane_test (
    input  logic [afc_pkg::PLANE_W-1:0] i_plane,
    input  afc_pkg::t_box               i_box,
    output afc_pkg::t_plane_hit         o_hit
);

    logic signed [15:0] w_nx, w_ny, w_nz, w_d;
    logic               w_px, w_py, w_pz;
    logic signed [15:0] w_nvx, w_nvy, w_nvz, w_pvx, w_pvy, w_pvz;
    logic signed [31:0] w_npx, w_npy, w_npz, w_ppx, w_ppy, w_ppz;
    logic signed [33:0] w_dterm, w_sum_neg, w_sum_pos;

    assign w_nx = i_plane[63:48];
    assign w_ny = i_plane[47:32];
    assign w_nz = i_plane[31:16];
    assign w_d  = i_plane[15:0];

    // strictly positive normal components
    assign w_px = !w_nx[15] && (w_nx != 16'sd0);
    assign w_py = !w_ny[15] && (w_ny != 16'sd0);
    assign w_pz = !w_nz[15] && (w_nz != 16'sd0);

    assign w_nvx = w_px ? i_box.min_x : i_box.max_x;
    assign w_nvy = w_py ? i_box.min_y : i_box.max_y;
    assign w_nvz = w_pz ? i_box.min_z : i_box.max_z;
    assign w_pvx = w_px ? i_box.max_x : i_box.min_x;
    assign w_pvy = w_py ? i_box.max_y : i_box.min_y;
    assign w_pvz = w_pz ? i_box.max_z : i_box.min_z;

    assign w_npx = w_nvx * w_nx;
    assign w_npy = w_nvy * w_ny;
    assign w_npz = w_nvz * w_nz;
    assign w_ppx = w_pvx * w_nx;
    assign w_ppy = w_pvy * w_ny;
    assign w_ppz = w_pvz * w_nz;

    // d moved from Q10.6 to the Q.20 grid of the products
    assign w_dterm = $signed({{4{w_d[15]}}, w_d, 14'b0});

    assign w_sum_neg = w_dterm
                     + $signed({{2{w_npx[31]}}, w_npx})
                     + $signed({{2{w_npy[31]}}, w_npy})
                     + $signed({{2{w_npz[31]}}, w_npz});
    assign w_sum_pos = w_dterm
                     + $signed({{2{w_ppx[31]}}, w_ppx})
                     + $signed({{2{w_ppy[31]}}, w_ppy})
                     + $signed({{2{w_ppz[31]}}, w_ppz});

    assign o_hit.neg_out = !w_sum_neg[33] && (w_sum_neg != 34'sd0);
    assign o_hit.pos_out = !w_sum_pos[33] && (w_sum_pos != 34'sd0);

endmodule

// ===== design/aabb_frustum_cull_unit.sv =====
// Classifies one axis-aligned box (Q10.6 min and max corners) against six
// frustum planes loaded by software: each plane is one 64-bit register with
// the normal x, y, z in Q1.14 and the offset d in Q10.6. The result is
// 0 fully inside, 1 partly clipped, 2 not visible (some negative vertex
// strictly outside a plane). One box is accepted every clock unless
// o_in_stall is high; the input register and the result register bound
// the 36 parallel 16x16 multipliers and the adder trees of the six plane
// tests. Planes reset to zero, so every box is fully inside until they are
// written; writes to an index above 5 are dropped. The user must have planes
// written only while no box is in flight; the block does not enforce it.
module aabb_frustum_cull_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [afc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]     i_cfg_data,
    // box input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [15:0]              i_box_min_x,
    input  logic signed [15:0]              i_box_min_y,
    input  logic signed [15:0]              i_box_min_z,
    input  logic signed [15:0]              i_box_max_x,
    input  logic signed [15:0]              i_box_max_y,
    input  logic signed [15:0]              i_box_max_z,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_clip_class
);

    // plane registers
    logic [afc_pkg::PLANE_W-1:0] r_plane [afc_pkg::NUM_PLANES];

    // input stage
    logic          r_s1_valid;
    afc_pkg::t_box r_box;

    // result stage
    logic                 r_out_valid;
    afc_pkg::t_clip_class r_class;
    afc_pkg::t_clip_class n_class;

    afc_pkg::t_plane_hit             w_hit [afc_pkg::NUM_PLANES];
    logic [afc_pkg::NUM_PLANES-1:0]  w_neg_out;
    logic [afc_pkg::NUM_PLANES-1:0]  w_pos_out;
    logic                            w_adv;
    logic                            w_in_take;

    // result register can load when empty or being drained
    assign w_adv      = !r_out_valid || !i_out_stall;
    // input register frees up when its box moves on in this cycle
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // plane writes, out-of-range index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
                r_plane[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
                if (i_cfg_index == afc_pkg::CFG_INDEX_W'(i)) begin
                    r_plane[i] <= i_cfg_data;
                end
            end
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_box.min_x <= i_box_min_x;
            r_box.min_y <= i_box_min_y;
            r_box.min_z <= i_box_min_z;
            r_box.max_x <= i_box_max_x;
            r_box.max_y <= i_box_max_y;
            r_box.max_z <= i_box_max_z;
        end
    end

    // six plane tests side by side
    for (genvar g = 0; g < afc_pkg::NUM_PLANES; g++) begin : g_plane
        afc_plane_test u_test (
            .i_plane (r_plane[g]),
            .i_box   (r_box),
            .o_hit   (w_hit[g])
        );
        assign w_neg_out[g] = w_hit[g].neg_out;
        assign w_pos_out[g] = w_hit[g].pos_out;
    end

    // any negative vertex outside wins over clipping
    always_comb begin
        priority if (|w_neg_out) begin
            n_class = afc_pkg::CLASS_HIDDEN;
        end else if (|w_pos_out) begin
            n_class = afc_pkg::CLASS_CLIPPED;
        end else begin
            n_class = afc_pkg::CLASS_INSIDE;
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_class <= n_class;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_clip_class = r_class;

    // a box held back by a stalled output keeps its slot and its corners
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_out_stall
        |=> r_s1_valid && $stable(r_box))
        else $error("input stage lost a box under output stall");

    // a box that moves on always lands in the result register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_adv |=> r_out_valid)
        else $error("box dropped between stages");

    // a drained result with nothing behind it leaves the output empty
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_stall && !r_s1_valid |=> !r_out_valid)
        else $error("result repeated after transaction");

    // a transaction into an empty pipe passes the input register, then shows up in the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && !r_s1_valid && !r_out_valid |=> ##1 r_out_valid)
        else $error("result missing two cycles after transaction");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // register indexes of the plane write port, two spare codes past the last plane
    typedef enum logic [afc_pkg::CFG_INDEX_W-1:0] {
        REG_NEAR,
        REG_FAR,
        REG_LEFT,
        REG_RIGHT,
        REG_TOP,
        REG_BOTTOM,
        REG_SPARE_A,
        REG_SPARE_B
    } t_plane_reg;

    localparam int ONE_Q14      = 16384;    // 1.0 in Q1.14
    localparam int DIAG_Q14     = 11585;    // 1/sqrt(2) in Q1.14
    localparam int HOLD_CYCLES  = 40;       // long receiver hold-off
    localparam int STUCK_LIMIT  = 1000;     // cycles with no transaction at all

    // tracks the plane setup and the classes still owed by the block
    class cull_tracker;
        bit [afc_pkg::PLANE_W-1:0] plane_copy [afc_pkg::NUM_PLANES];
        afc_pkg::t_clip_class      owed_class [$];
        int unsigned               errors;

        function void load_plane(int unsigned idx, bit [afc_pkg::PLANE_W-1:0] value);
            if (idx < afc_pkg::NUM_PLANES)
                plane_copy[idx] = value;
        endfunction

        // negative/positive vertex test against all six planes
        function afc_pkg::t_clip_class classify_box(afc_pkg::t_box b);
            longint lo [3];
            longint hi [3];
            longint nml [3];
            longint neg_dist;
            longint pos_dist;
            bit     partly;
            partly = 1'b0;
            lo[0] = longint'(b.min_x);
            lo[1] = longint'(b.min_y);
            lo[2] = longint'(b.min_z);
            hi[0] = longint'(b.max_x);
            hi[1] = longint'(b.max_y);
            hi[2] = longint'(b.max_z);
            for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
                nml[0]   = longint'($signed(plane_copy[p][63:48]));
                nml[1]   = longint'($signed(plane_copy[p][47:32]));
                nml[2]   = longint'($signed(plane_copy[p][31:16]));
                // offset moves from Q10.6 to the Q.20 of the products
                neg_dist = longint'($signed(plane_copy[p][15:0])) * ONE_Q14;
                pos_dist = neg_dist;
                for (int a = 0; a < 3; a++) begin
                    if (nml[a] > 0) begin
                        neg_dist += lo[a] * nml[a];
                        pos_dist += hi[a] * nml[a];
                    end else begin
                        neg_dist += hi[a] * nml[a];
                        pos_dist += lo[a] * nml[a];
                    end
                end
                if (neg_dist > 0)
                    return afc_pkg::CLASS_HIDDEN;
                if (pos_dist > 0)
                    partly = 1'b1;
            end
            return partly ? afc_pkg::CLASS_CLIPPED : afc_pkg::CLASS_INSIDE;
        endfunction

        function void note_box(afc_pkg::t_box b);
            owed_class.push_back(classify_box(b));
        endfunction

        function void check_class(logic [1:0] got);
            afc_pkg::t_clip_class want;
            if (owed_class.size() == 0) begin
                $error("clip_class: result with no box in flight, actual %0d", got);
                errors++;
            end else begin
                want = owed_class.pop_front();
                if (got !== want) begin
                    $error("clip_class: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_cfg_we     = 1'b0;
    logic [afc_pkg::CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [afc_pkg::PLANE_W-1:0]     i_cfg_data   = '0;
    logic                            i_in_valid   = 1'b0;
    logic                            o_in_stall;
    logic signed [15:0]              i_box_min_x  = '0;
    logic signed [15:0]              i_box_min_y  = '0;
    logic signed [15:0]              i_box_min_z  = '0;
    logic signed [15:0]              i_box_max_x  = '0;
    logic signed [15:0]              i_box_max_y  = '0;
    logic signed [15:0]              i_box_max_z  = '0;
    logic                            o_out_valid;
    logic                            i_out_stall  = 1'b0;
    logic [1:0]                      o_clip_class;

    cull_tracker sb = new();

    bit idle_on         = 1'b1;     // random gaps and stalls on both sides
    bit stall_burst_req = 1'b0;     // asks the receiver for one long hold-off
    int stuck_cycles    = 0;

    aabb_frustum_cull_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check every result transaction, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_class(o_clip_class);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver stall pattern, with the long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < 23);
            end
        end
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic afc_pkg::t_box box_of(int mnx, int mny, int mnz,
                                             int mxx, int mxy, int mxz);
        afc_pkg::t_box b;
        b.min_x = clamp16(mnx);
        b.min_y = clamp16(mny);
        b.min_z = clamp16(mnz);
        b.max_x = clamp16(mxx);
        b.max_y = clamp16(mxy);
        b.max_z = clamp16(mxz);
        return b;
    endfunction

    function automatic bit [afc_pkg::PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        return {16'(nx), 16'(ny), 16'(nz), 16'(d)};
    endfunction

    // mostly proper boxes around the planes, some inverted, some raw bits
    function automatic afc_pkg::t_box random_box(int span);
        int            ctr [3];
        int            half [3];
        int            pick;
        afc_pkg::t_box b;
        pick = $urandom_range(99);
        if (pick < 8)
            return afc_pkg::t_box'({$urandom, $urandom, $urandom});
        for (int a = 0; a < 3; a++) begin
            ctr[a]  = int'($urandom_range(2 * span)) - span;
            half[a] = (pick < 60) ? int'($urandom_range(span / 16))
                                  : int'($urandom_range(span / 2));
        end
        b = box_of(ctr[0] - half[0], ctr[1] - half[1], ctr[2] - half[2],
                   ctr[0] + half[0], ctr[1] + half[1], ctr[2] + half[2]);
        // inverted corners go in unchanged
        if (pick < 14)
            b = {b.max_x, b.max_y, b.max_z, b.min_x, b.min_y, b.min_z};
        return b;
    endfunction

    // called in the time step of the previous transaction (or with valid low)
    task automatic send_box(afc_pkg::t_box b);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < 23)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_box_min_x <= b.min_x;
        i_box_min_y <= b.min_y;
        i_box_min_z <= b.min_z;
        i_box_max_x <= b.max_x;
        i_box_max_y <= b.max_y;
        i_box_max_z <= b.max_z;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        sb.note_box(b);
    endtask

    task automatic wait_drained();
        while (sb.owed_class.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_plane(t_plane_reg idx, bit [afc_pkg::PLANE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.load_plane(idx, value);
    endtask

    task automatic load_frustum(bit [afc_pkg::PLANE_W-1:0] planes [afc_pkg::NUM_PLANES]);
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            write_plane(t_plane_reg'(p), planes[p]);
        i_cfg_we <= 1'b0;
    endtask

    // random boxes; optional long hold-off and a drain pause part way through
    task automatic run_random(int count, int span, int hold_at, int drain_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at)
                stall_burst_req = 1'b1;
            if (k == drain_at) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            send_box(random_box(span));
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        bit [afc_pkg::PLANE_W-1:0] planes [afc_pkg::NUM_PLANES];
        int                        lim;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // planes still at reset: every box is fully inside
        send_box(box_of(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(box_of(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(box_of(32767, 32767, 32767, -32768, -32768, -32768));
        run_random(150, 32767, -1, -1);
        wait_drained();

        // cube of half width 100.0, axis normals so two components are zero
        lim = 6400;
        planes[REG_NEAR]   = pack_plane(0, 0, -ONE_Q14, -lim);
        planes[REG_FAR]    = pack_plane(0, 0, ONE_Q14, -lim);
        planes[REG_LEFT]   = pack_plane(-ONE_Q14, 0, 0, -lim);
        planes[REG_RIGHT]  = pack_plane(ONE_Q14, 0, 0, -lim);
        planes[REG_TOP]    = pack_plane(0, ONE_Q14, 0, -lim);
        planes[REG_BOTTOM] = pack_plane(0, -ONE_Q14, 0, -lim);
        load_frustum(planes);
        send_box(box_of(-640, -640, -640, 640, 640, 640));          // inside
        send_box(box_of(6000, 0, 0, 7000, 100, 100));               // crosses right
        send_box(box_of(7000, 0, 0, 8000, 100, 100));               // past right
        send_box(box_of(-8000, 0, 0, -7000, 100, 100));             // past left
        send_box(box_of(0, 7000, 0, 100, 7100, 100));               // past top
        send_box(box_of(0, 0, -9000, 100, 100, -6500));             // past near
        send_box(box_of(0, -6500, 0, 100, 6500, 100));              // crosses top and bottom
        send_box(box_of(0, 0, 6400, 100, 100, 6400));               // touches far, not outside
        send_box(box_of(0, 0, 6401, 100, 100, 6402));               // just past far
        send_box(box_of(-6400, -6400, -6400, 6400, 6400, 6400));    // exactly the cube
        send_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(box_of(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(box_of(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(box_of(32767, 32767, 32767, -32768, -32768, -32768));  // inverted, huge
        send_box(box_of(640, 640, 640, -640, -640, -640));          // inverted, small
        i_in_valid <= 1'b0;
        wait_drained();

        // same shape, other size; long receiver hold-off while boxes keep coming
        lim = $urandom_range(3000, 12000);
        planes[REG_NEAR]   = pack_plane(0, 0, -ONE_Q14, -lim);
        planes[REG_FAR]    = pack_plane(0, 0, ONE_Q14, -lim);
        planes[REG_LEFT]   = pack_plane(-ONE_Q14, 0, 0, -lim);
        planes[REG_RIGHT]  = pack_plane(ONE_Q14, 0, 0, -lim);
        planes[REG_TOP]    = pack_plane(0, ONE_Q14, 0, -lim);
        planes[REG_BOTTOM] = pack_plane(0, -ONE_Q14, 0, -lim);
        load_frustum(planes);
        run_random(350, lim * 3 / 2, 120, -1);
        wait_drained();

        // 90 degree perspective looking down -z, no idling on either side
        planes[REG_NEAR]   = pack_plane(0, 0, ONE_Q14, 64);
        planes[REG_FAR]    = pack_plane(0, 0, -ONE_Q14, -20000);
        planes[REG_LEFT]   = pack_plane(-DIAG_Q14, 0, DIAG_Q14, 0);
        planes[REG_RIGHT]  = pack_plane(DIAG_Q14, 0, DIAG_Q14, 0);
        planes[REG_TOP]    = pack_plane(0, DIAG_Q14, DIAG_Q14, 0);
        planes[REG_BOTTOM] = pack_plane(0, -DIAG_Q14, DIAG_Q14, 0);
        load_frustum(planes);
        idle_on = 1'b0;
        run_random(350, 20000, -1, -1);
        wait_drained();
        idle_on = 1'b1;

        // raw register bits; the sender pauses once until all results are in
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            planes[p] = {$urandom, $urandom};
        load_frustum(planes);
        run_random(300, 32767, -1, 150);
        wait_drained();

        // random normals within +-1.0 and moderate offsets
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            planes[p] = pack_plane(int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                                   int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                                   int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                                   int'($urandom_range(24000)) - 12000);
        load_frustum(planes);
        run_random(350, 16000, -1, -1);
        wait_drained();

        // extreme register contents
        planes[REG_NEAR]   = 64'h7FFF_7FFF_7FFF_7FFF;
        planes[REG_FAR]    = 64'h8000_8000_8000_8000;
        planes[REG_LEFT]   = 64'hFFFF_FFFF_FFFF_FFFF;
        planes[REG_RIGHT]  = 64'h8000_7FFF_8000_7FFF;
        planes[REG_TOP]    = 64'h7FFF_8000_7FFF_8000;
        planes[REG_BOTTOM] = 64'h0000_0000_0000_8000;
        load_frustum(planes);
        run_random(150, 32767, -1, -1);
        wait_drained();

        // back to zero planes; writes past the last plane must not land anywhere
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            planes[p] = '0;
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            write_plane(t_plane_reg'(p), planes[p]);
        write_plane(REG_SPARE_A, 64'h7FFF_7FFF_7FFF_7FFF);
        write_plane(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
        i_cfg_we <= 1'b0;
        run_random(150, 32767, -1, -1);

        // drain, then wait a while for any stray result
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_class.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
